// ----- sv/esl_pkg.sv -----
// Shared types and constants for the encoder integral speed loop.
`default_nettype none

package esl_pkg;

    localparam int unsigned TICK_W  = 24;
    localparam int unsigned DIV_W   = 16;
    localparam int unsigned SPEED_W = 8;
    localparam int unsigned DUTY_W  = 17;
    localparam int unsigned PROD_W  = 26;
    localparam int unsigned SUM_W   = 27;
    localparam int unsigned STEP_W  = 3;

    localparam logic [DUTY_W-1:0] FULL_DRIVE = 17'd65536;

    // Register selects (address bit 2)
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_TPR  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_ACC  = 4'b1000
    } t_state;

    typedef struct packed {
        logic enc;   // count one encoder edge
        logic load;  // take an update request, start the divider
        logic step;  // one quotient bit
        logic mul;   // error times gain
        logic acc;   // integrate, clamp, load the output register
    } t_cmd;

    typedef struct packed {
        logic out_busy;  // output register holds a result not yet taken
    } t_status;

endpackage

`default_nettype wire

// ----- sv/encoder_integral_speed_loop_top.sv -----
// Top level of the encoder integral speed loop: register port, controller and datapath.
// An encoder-edge request (mode 0) may follow every cycle while the input is not stalled;
// it only bumps a saturating 24-bit tick counter. A control-update request (mode 1) holds
// the input stalled after it is taken, through the one-bit-per-cycle quotient divider
// (tick count over ticks_per_rev, saturated at 255), then error times gain, then the
// clamped integration. It waits longer only while the previous result still sits in
// the output register. Registers: gain at 0x0, ticks_per_rev at 0x4; the decode uses
// address bit 2.
`default_nettype none

module encoder_integral_speed_loop_top
    import esl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_mode,
    input  wire logic signed [7:0] i_target_speed,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [DUTY_W-1:0]      o_duty,
    output logic                   o_direction,
    output logic [SPEED_W-1:0]     o_measured_speed,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [DIV_W-1:0] r_gain;
    logic [DIV_W-1:0] r_tpr;
    logic             wr_en;
    t_cmd             cmd;
    t_status          status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 16'd2621;
            r_tpr  <= 16'd4096;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_GAIN: r_gain <= pwdata[DIV_W-1:0];
                REG_TPR:  r_tpr  <= pwdata[DIV_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GAIN: prdata = {16'b0, r_gain};
            REG_TPR:  prdata = {16'b0, r_tpr};
            default:  prdata = '0;
        endcase
    end

    esl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    esl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_target_speed   (i_target_speed),
        .i_gain           (r_gain),
        .i_ticks_per_rev  (r_tpr),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_duty           (o_duty),
        .o_direction      (o_direction),
        .o_measured_speed (o_measured_speed)
    );

endmodule

`default_nettype wire

// ----- sv/esl_ctrl.sv -----
// Controller state machine for the encoder integral speed loop.
`default_nettype none

module esl_ctrl
    import esl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_mode,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.enc  = i_in_valid && !i_mode;
                o_cmd.load = i_in_valid && i_mode;
                if (o_cmd.load) begin
                    n_state = S_DIV;
                    n_cnt   = '1;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                // wait for the previous result to leave
                if (!i_status.out_busy) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- sv/esl_dp.sv -----
// Datapath: tick counter, bit-serial divider, multiplier, integrator, output register.
`default_nettype none

module esl_dp
    import esl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic signed [7:0]  i_target_speed,
    input  wire logic [DIV_W-1:0]   i_gain,
    input  wire logic [DIV_W-1:0]   i_ticks_per_rev,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output logic [DUTY_W-1:0]       o_duty,
    output logic                    o_direction,
    output logic [SPEED_W-1:0]      o_measured_speed
);

    logic [TICK_W-1:0]        r_tick;
    logic [TICK_W-1:0]        r_rem;
    logic [TICK_W-1:0]        r_dsh;
    logic [SPEED_W-1:0]       r_quot;
    logic                     r_sat;
    logic [SPEED_W-1:0]       r_mag;
    logic                     r_dir;
    logic signed [PROD_W-1:0] r_prod;
    logic [DUTY_W-1:0]        r_drive;
    logic                     r_out_valid;
    logic [DUTY_W-1:0]        r_duty;
    logic                     r_direction;
    logic [SPEED_W-1:0]       r_speed;

    logic [DIV_W-1:0]         div_eff;
    logic [SPEED_W-1:0]       speed;
    logic signed [PROD_W-1:0] err_x;
    logic signed [PROD_W-1:0] gain_x;
    logic signed [SUM_W-1:0]  sum;
    logic [DUTY_W-1:0]        drive_nx;
    logic                     rem_ge;

    assign div_eff = (i_ticks_per_rev == '0) ? DIV_W'(1) : i_ticks_per_rev;
    assign rem_ge  = (r_rem >= r_dsh);
    assign speed   = r_sat ? '1 : r_quot;
    assign err_x   = PROD_W'($signed({1'b0, r_mag})) - PROD_W'($signed({1'b0, speed}));
    assign gain_x  = $signed({{(PROD_W-DIV_W){1'b0}}, i_gain});
    assign sum     = $signed({{(SUM_W-DUTY_W){1'b0}}, r_drive}) + SUM_W'(r_prod);

    always_comb begin
        if (sum < 0) begin
            drive_nx = '0;
        end else if (sum > $signed({{(SUM_W-DUTY_W){1'b0}}, FULL_DRIVE})) begin
            drive_nx = FULL_DRIVE;
        end else begin
            drive_nx = sum[DUTY_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_tick <= '0;
            end else if (i_cmd.enc && r_tick != '1) begin
                r_tick <= r_tick + 1'b1;
            end
            if (i_cmd.acc) begin
                r_drive <= drive_nx;
            end
            if (i_cmd.acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= r_tick;
            r_dsh  <= {1'b0, div_eff, 7'b0};
            r_sat  <= (r_tick >= {div_eff, 8'b0});
            r_mag  <= i_target_speed[7] ? SPEED_W'(-i_target_speed) : i_target_speed;
            r_dir  <= i_target_speed[7] || (i_target_speed == '0);
        end
        if (i_cmd.step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quot <= {r_quot[SPEED_W-2:0], rem_ge};
            r_dsh  <= r_dsh >> 1;
        end
        if (i_cmd.mul) begin
            r_prod <= err_x * gain_x;
        end
        if (i_cmd.acc) begin
            r_duty      <= drive_nx;
            r_direction <= r_dir;
            r_speed     <= speed;
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_duty            = r_duty;
    assign o_direction       = r_direction;
    assign o_measured_speed  = r_speed;

endmodule

`default_nettype wire

// ----- sv/esl_checker.sv -----
// Port-level checks for the encoder integral speed loop, bound to the top level.
`default_nettype none

module esl_checker
    import esl_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              i_mode,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [DUTY_W-1:0] o_duty
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty <= FULL_DRIVE))
        else $error("duty above full drive");

    // an update request keeps the block busy on the following cycle
    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_mode |=> o_in_stall)
        else $error("update request did not start the divider");

    // a new result only follows a busy cycle
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an update in progress");

endmodule

bind encoder_integral_speed_loop_top esl_checker u_esl_checker (.*);

`default_nettype wire
